@@ rtl/core/ccsg_pkg.sv @@
// shared types and constants for the circle column span generator
// no dependencies
`default_nettype none

package ccsg_pkg;

  localparam int COORD_W = 10;
  localparam int RADIUS_W = 8;
  localparam int ROW_W = 12;
  localparam int COLOR_W = 16;
  localparam int SQ_W = 2 * RADIUS_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ROOT_STEPS = SQ_W / 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR = 3'd4;

  localparam logic [1:0] HALF_SOUTH = 2'd1;
  localparam logic [1:0] HALF_NORTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                done;
    logic [RADIUS_W-1:0] root;
    logic                inexact;
  } root_status_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] first_row;
    logic signed [ROW_W-1:0] last_row;
  } span_t;

endpackage

`default_nettype wire

@@ rtl/core/ccsg_col_if.sv @@
// column channel: one screen column per word
// depends on ccsg_pkg
`default_nettype none

interface ccsg_col_if import ccsg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink (input valid, input column, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ccsg_span_if.sv @@
// span channel: south and north spans of one column per word
// depends on ccsg_pkg
`default_nettype none

interface ccsg_span_if import ccsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COORD_W-1:0]      span_column;
  logic                    outside;
  logic                    south_valid;
  logic signed [ROW_W-1:0] south_start;
  logic signed [ROW_W-1:0] south_end;
  logic                    north_valid;
  logic signed [ROW_W-1:0] north_start;
  logic signed [ROW_W-1:0] north_end;
  logic [COLOR_W-1:0]      span_color;

  modport source (output valid, output span_column, output outside, output south_valid,
                  output south_start, output south_end, output north_valid,
                  output north_start, output north_end, output span_color, input ready);
  modport sink (input valid, input span_column, input outside, input south_valid,
                input south_start, input south_end, input north_valid,
                input north_start, input north_end, input span_color, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ccsg_isqrt.sv @@
// bit-serial integer square root, one result bit per cycle
// depends on ccsg_pkg
`default_nettype none

module ccsg_isqrt import ccsg_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] value,
  output root_status_t         status
);

  localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (SQ_W - 2);
  localparam int CNT_W = $clog2(ROOT_STEPS);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [SQ_W-1:0]  rem;
  logic [SQ_W-1:0]  res;
  logic [SQ_W-1:0]  bitv;
  logic             done;

  logic [SQ_W:0]   trial;
  logic            take;
  logic [SQ_W-1:0] rem_next;
  logic [SQ_W-1:0] res_next;

  always_comb begin
    trial = {1'b0, res} + {1'b0, bitv};
    take = {1'b0, rem} >= trial;
    rem_next = take ? rem - trial[SQ_W-1:0] : rem;
    res_next = take ? (res >> 1) + bitv : res >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= value;
      res <= '0;
      bitv <= BIT_INIT;
    end else if (busy) begin
      rem <= rem_next;
      res <= res_next;
      bitv <= bitv >> 2;
    end
  end

  assign status.done = done;
  assign status.root = res[RADIUS_W-1:0];
  assign status.inexact = rem != '0;

endmodule

`default_nettype wire

@@ rtl/core/circle_column_span_generator.sv @@
// circle column span generator: per column, south and north arc spans
// depends on ccsg_pkg, ccsg_col_if, ccsg_span_if, ccsg_isqrt
//
//   channel   dir   word
//   columns   in    column x
//   spans     out   column, outside flag, south span, north span, color
//   wr_*      in    register writes, no read-back
//
// a column inside the circle passes from accept to a loaded result register
// through check, square, 8 root steps and the done strobe of the bit-serial
// root unit, then span compare; an outside column goes from check to span compare
// columns is ready only while the sequencer is idle; one result waits in the
// output register while the next column is already accepted
// a stalled result holds the sequencer at the span compare step
// rst is synchronous, clears the config registers, the sequencer state, both previous rows and the handshake
`default_nettype none

module circle_column_span_generator import ccsg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  ccsg_col_if.sink                   columns,
  ccsg_span_if.source                spans
);

  logic [COORD_W-1:0]  center_x;
  logic [COORD_W-1:0]  center_y;
  logic [RADIUS_W-1:0] radius;
  logic [1:0]          half_select;
  logic [COLOR_W-1:0]  pixel_color;

  logic signed [ROW_W-1:0] prev_south_row;
  logic signed [ROW_W-1:0] prev_north_row;

  state_t state;
  state_t state_next;

  logic [COORD_W-1:0]  col;
  logic [RADIUS_W-1:0] adx_r;
  logic                first_r;
  logic                outside_r;
  logic [SQ_W-1:0]     rsq;
  logic [SQ_W-1:0]     v;

  logic         root_start;
  root_status_t root_st;

  logic out_valid;

  logic signed [COORD_W:0] dx;
  logic [COORD_W:0]        dx_neg;
  logic [COORD_W-1:0]      adx;
  logic                    outside;
  logic                    out_free;

  logic [RADIUS_W:0]       sc;
  logic signed [ROW_W-1:0] q_south;
  logic signed [ROW_W-1:0] q_north;
  logic                    south_on;
  logic                    north_on;
  span_t                   south_span;
  span_t                   north_span;

  function automatic span_t make_span(logic signed [ROW_W-1:0] prev,
                                      logic signed [ROW_W-1:0] q, logic first);
    span_t                   s;
    logic signed [ROW_W-1:0] p;
    p = first ? q : prev;
    if (p <= q) begin
      s.first_row = p;
      s.last_row = q;
    end else begin
      s.first_row = q;
      s.last_row = p - ROW_W'(1);
    end
    return s;
  endfunction

  ccsg_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .value  (v),
    .status (root_st)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius <= '0;
      half_select <= '0;
      pixel_color <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER_X:    center_x <= wr_data[COORD_W-1:0];
        REG_CENTER_Y:    center_y <= wr_data[COORD_W-1:0];
        REG_RADIUS:      radius <= wr_data[RADIUS_W-1:0];
        REG_HALF_SELECT: half_select <= wr_data[1:0];
        REG_PIXEL_COLOR: pixel_color <= wr_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dx = $signed({1'b0, col}) - $signed({1'b0, center_x});
    dx_neg = -dx;
    adx = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
    outside = adx > {{(COORD_W - RADIUS_W){1'b0}}, radius};
    out_free = !out_valid || spans.ready;
    v = rsq - {{RADIUS_W{1'b0}}, adx_r} * {{RADIUS_W{1'b0}}, adx_r};

    sc = {1'b0, root_st.root} + {{RADIUS_W{1'b0}}, root_st.inexact};
    q_south = $signed({{(ROW_W - COORD_W){1'b0}}, center_y})
            + $signed({{(ROW_W - RADIUS_W){1'b0}}, root_st.root});
    q_north = $signed({{(ROW_W - COORD_W){1'b0}}, center_y})
            - $signed({{(ROW_W - RADIUS_W - 1){1'b0}}, sc});
    south_on = half_select != HALF_NORTH;
    north_on = half_select != HALF_SOUTH;
    south_span = make_span(prev_south_row, q_south, first_r);
    north_span = make_span(prev_north_row, q_north, first_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    root_start = 1'b0;
    columns.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        columns.ready = 1'b1;
        if (columns.valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = outside ? ST_FINISH : ST_SQUARE;
      end
      ST_SQUARE: begin
        root_start = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_st.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // column datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (columns.valid) col <= columns.column;
      end
      ST_CHECK: begin
        outside_r <= outside;
        adx_r <= adx[RADIUS_W-1:0];
        first_r <= (adx == {{(COORD_W - RADIUS_W){1'b0}}, radius}) &&
                   (dx[COORD_W] || (adx == '0));
        rsq <= {{RADIUS_W{1'b0}}, radius} * {{RADIUS_W{1'b0}}, radius};
      end
      default: ;
    endcase
  end

  // previous rows
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_south_row <= '0;
      prev_north_row <= '0;
    end else if (state == ST_FINISH && out_free && !outside_r) begin
      if (south_on) prev_south_row <= q_south;
      if (north_on) prev_north_row <= q_north;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (spans.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      spans.span_column <= col;
      spans.outside <= outside_r;
      spans.span_color <= pixel_color;
      spans.south_valid <= !outside_r && south_on;
      spans.north_valid <= !outside_r && north_on;
      if (!outside_r && south_on) begin
        spans.south_start <= south_span.first_row;
        spans.south_end <= south_span.last_row;
      end else begin
        spans.south_start <= '0;
        spans.south_end <= '0;
      end
      if (!outside_r && north_on) begin
        spans.north_start <= north_span.first_row;
        spans.north_end <= north_span.last_row;
      end else begin
        spans.north_start <= '0;
        spans.north_end <= '0;
      end
    end
  end

  assign spans.valid = out_valid;

endmodule

`default_nettype wire

@@ tb/sv/ccsg_tb_pkg.sv @@
`timescale 1ns / 100ps
// span word type and scoreboard for the circle column span generator bench
// predicts south/north arc spans per accepted column; depends on ccsg_pkg
package ccsg_tb_pkg;
  import ccsg_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0]      span_column;
    logic                    outside;
    logic                    south_valid;
    logic signed [ROW_W-1:0] south_start;
    logic signed [ROW_W-1:0] south_end;
    logic                    north_valid;
    logic signed [ROW_W-1:0] north_start;
    logic signed [ROW_W-1:0] north_end;
    logic [COLOR_W-1:0]      span_color;
  } span_word_t;

  class span_scoreboard;
    logic [COORD_W-1:0]  center_x;
    logic [COORD_W-1:0]  center_y;
    logic [RADIUS_W-1:0] radius;
    logic [1:0]          half_select;
    logic [COLOR_W-1:0]  pixel_color;
    int                  prev_south;
    int                  prev_north;
    span_word_t          expected_spans[$];
    int                  errors;

    function new();
      center_x = '0;
      center_y = '0;
      radius = '0;
      half_select = '0;
      pixel_color = '0;
      prev_south = 0;
      prev_north = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_CENTER_X:    center_x = value[COORD_W-1:0];
        REG_CENTER_Y:    center_y = value[COORD_W-1:0];
        REG_RADIUS:      radius = value[RADIUS_W-1:0];
        REG_HALF_SELECT: half_select = value[1:0];
        REG_PIXEL_COLOR: pixel_color = value[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function int floor_root(int v);
      int s;
      s = 0;
      while ((s + 1) * (s + 1) <= v) s++;
      return s;
    endfunction

    function void arc_span(inout int prev, input int point, input bit seed,
                           output logic signed [ROW_W-1:0] lo,
                           output logic signed [ROW_W-1:0] hi);
      if (seed) prev = point;
      if (prev <= point) begin
        lo = prev[ROW_W-1:0];
        hi = point[ROW_W-1:0];
      end else begin
        lo = point[ROW_W-1:0];
        hi = (prev - 1) & 'hFFF;
      end
      prev = point;
    endfunction

    function void add_column(logic [COORD_W-1:0] col);
      span_word_t w;
      int dx;
      int adx;
      int v;
      int s;
      int s_up;
      bit seed;
      w = '0;
      w.span_column = col;
      w.span_color = pixel_color;
      dx = int'(col) - int'(center_x);
      adx = (dx < 0) ? -dx : dx;
      if (adx > int'(radius)) begin
        w.outside = 1'b1;
      end else begin
        v = int'(radius) * int'(radius) - adx * adx;
        s = floor_root(v);
        s_up = (s * s == v) ? s : s + 1;
        seed = (dx == -int'(radius));
        if (half_select != HALF_NORTH) begin
          w.south_valid = 1'b1;
          arc_span(prev_south, int'(center_y) + s, seed, w.south_start, w.south_end);
        end
        if (half_select != HALF_SOUTH) begin
          w.north_valid = 1'b1;
          arc_span(prev_north, int'(center_y) - s_up, seed, w.north_start, w.north_end);
        end
      end
      expected_spans.push_back(w);
    endfunction

    function void compare_field(string field, int col, int want, int got);
      if (want != got) begin
        $display("%0t: column %0d %s expected %0d actual %0d", $time, col, field, want, got);
        errors++;
      end
    endfunction

    function void check_span(span_word_t got);
      span_word_t want;
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected span word, column %0d", $time, got.span_column);
        errors++;
        return;
      end
      want = expected_spans.pop_front();
      compare_field("span_column", want.span_column, want.span_column, got.span_column);
      compare_field("outside", want.span_column, want.outside, got.outside);
      compare_field("south_valid", want.span_column, want.south_valid, got.south_valid);
      compare_field("south_start", want.span_column,
                    $signed(want.south_start), $signed(got.south_start));
      compare_field("south_end", want.span_column,
                    $signed(want.south_end), $signed(got.south_end));
      compare_field("north_valid", want.span_column, want.north_valid, got.north_valid);
      compare_field("north_start", want.span_column,
                    $signed(want.north_start), $signed(got.north_start));
      compare_field("north_end", want.span_column,
                    $signed(want.north_end), $signed(got.north_end));
      compare_field("span_color", want.span_column, want.span_color, got.span_color);
    endfunction

    function int outstanding();
      return expected_spans.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_circle_column_span_generator.sv @@
`timescale 1ns / 100ps
// top-level bench for circle_column_span_generator: directed and random circle sweeps
// depends on ccsg_pkg, ccsg_col_if, ccsg_span_if and ccsg_tb_pkg
module tb_circle_column_span_generator;
  import ccsg_pkg::*;
  import ccsg_tb_pkg::*;

  localparam int ITEM_COUNT = 1050;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 16;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  ccsg_col_if  col_ch ();
  ccsg_span_if span_ch ();

  circle_column_span_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .columns  (col_ch),
    .spans    (span_ch)
  );

  span_scoreboard sb;
  int src_idle;
  int snk_idle;
  int hold_request;
  int hold_taken;
  int hold_left;
  int items_sent;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // span sink with random stalls and requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      span_ch.ready <= 1'b0;
    end else begin
      if (span_ch.valid && span_ch.ready) begin
        sb.check_span('{span_column: span_ch.span_column, outside: span_ch.outside,
                        south_valid: span_ch.south_valid, south_start: span_ch.south_start,
                        south_end: span_ch.south_end, north_valid: span_ch.north_valid,
                        north_start: span_ch.north_start, north_end: span_ch.north_end,
                        span_color: span_ch.span_color});
      end
      if (hold_request != hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = hold_request;
      end
      if (hold_left != 0) begin
        hold_left--;
        span_ch.ready <= 1'b0;
      end else begin
        span_ch.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (col_ch.valid && col_ch.ready) || (span_ch.valid && span_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** circle_column_span_generator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    col_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_column(input int col);
    while ($urandom_range(99) < src_idle) begin
      col_ch.valid <= 1'b0;
      col_ch.column <= COORD_W'($urandom);
      @(posedge clk);
    end
    col_ch.valid <= 1'b1;
    col_ch.column <= COORD_W'(col);
    do @(posedge clk); while (!col_ch.ready);
    sb.add_column(COORD_W'(col));
    items_sent++;
    src_idle = (items_sent < 350) ? 23 : (items_sent < 700) ? 65 : 0;
    snk_idle = (items_sent < 350) ? 65 : (items_sent < 700) ? 23 : 0;
    if (items_sent == 120 || items_sent == 600) hold_request++;
    if (items_sent == 300 || items_sent == 850) drain();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value,
                           input int width, input bit dirty);
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_DATA_W-1:0] mask;
    mask = CFG_DATA_W'((32'd1 << width) - 1);
    data = CFG_DATA_W'(value) & mask;
    if (dirty) data = data | (CFG_DATA_W'($urandom) & ~mask);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int cx, input int cy, input int r, input int half,
                           input int color, input bit dirty);
    drain();
    write_reg(REG_CENTER_X, cx, COORD_W, dirty);
    write_reg(REG_CENTER_Y, cy, COORD_W, dirty);
    write_reg(REG_RADIUS, r, RADIUS_W, dirty);
    write_reg(REG_HALF_SELECT, half, 2, dirty);
    write_reg(REG_PIXEL_COLOR, color, COLOR_W, dirty);
    wr_en <= 1'b0;
  endtask

  task automatic run_sweep(input int cx, input int r);
    for (int x = cx - r; x <= cx + r; x++) begin
      if (items_sent >= ITEM_COUNT) break;
      if (x < 0 || x > 1023) continue;
      if ($urandom_range(99) < 4) send_column($urandom_range(1023));
      if ($urandom_range(99) < 2) continue;
      send_column(x);
    end
  endtask

  function automatic int pick_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(1023);
    endcase
  endfunction

  initial begin
    int cx;
    int r;
    sb = new();
    src_idle = 23;
    snk_idle = 65;
    hold_request = 0;
    items_sent = 0;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_CENTER_X;
    wr_data <= '0;
    col_ch.valid <= 1'b0;
    col_ch.column <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero radius at column zero, then far outside
    send_column(0);
    send_column(1023);
    // small circle centred on the top edge, full sweep plus an outside column
    configure(10, 0, 3, 0, 'hFFFF, 1'b0);
    for (int x = 7; x <= 13; x++) send_column(x);
    send_column(500);
    // largest radius at the far corner, both-arc code three
    configure(1023, 1023, 255, 3, 0, 1'b0);
    send_column(768);
    send_column(769);
    send_column(1023);
    send_column(1022);
    // left edge off screen, south arc only
    configure(5, 512, 8, HALF_SOUTH, 'h5A5A, 1'b0);
    send_column(0);
    send_column(1);
    send_column(2);
    send_column(13);
    send_column(14);
    // north arc only
    configure(5, 512, 8, HALF_NORTH, 'hA5A5, 1'b0);
    send_column(3);
    send_column(4);

    while (items_sent < ITEM_COUNT) begin
      cx = pick_coord();
      r = ($urandom_range(39) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 24);
      configure(cx, pick_coord(), r, $urandom_range(3), $urandom_range(16'hFFFF),
                $urandom_range(3) == 0);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(5, 15)) send_column($urandom_range(1023));
      end else begin
        run_sweep(cx, r);
        if ($urandom_range(3) == 0) run_sweep(cx, r);
      end
    end

    drain();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** circle_column_span_generator: PASSED **");
    end else begin
      $display("** circle_column_span_generator: FAILED **");
    end
    $finish;
  end

endmodule
